// ----- rtl/core/wiep_pkg.sv -----
// ----------------------------------------------------------------------------
// wiep_pkg
// Shared types and constants for the information element parser.
// ----------------------------------------------------------------------------
package wiep_pkg;

    localparam logic [5:0] ELEMENT_CAP        = 6'd32;
    localparam logic [3:0] VENDOR_CAP         = 4'd8;
    localparam logic [4:0] RATE_CAP           = 5'd16;
    localparam logic [7:0] VENDOR_PAYLOAD_CAP = 8'd64;

    localparam logic [7:0] SKIP_RESET = 8'd12;

    localparam logic [7:0] ID_SSID      = 8'd0;
    localparam logic [7:0] ID_RATES     = 8'd1;
    localparam logic [7:0] ID_HT        = 8'd45;
    localparam logic [7:0] ID_EXT_RATES = 8'd50;
    localparam logic [7:0] ID_VHT       = 8'd191;
    localparam logic [7:0] ID_VENDOR    = 8'd221;

    localparam logic [7:0] SSID_MAX_LEN  = 8'd32;
    localparam logic [7:0] PRINT_LO      = 8'd32;
    localparam logic [7:0] PRINT_HI      = 8'd126;
    localparam logic [7:0] RATE_MAX_LEN  = 8'd16;
    localparam logic [7:0] RATE_MASK     = 8'h7F;
    localparam logic [7:0] HT_MIN_LEN    = 8'd26;
    localparam logic [7:0] VHT_MIN_LEN   = 8'd12;
    localparam logic [7:0] VENDOR_MIN_LEN = 8'd3;
    localparam logic [7:0] VENDOR_TYPE_POS = 8'd3;
    localparam logic [7:0] VENDOR_PAY_POS  = 8'd4;

    localparam logic [2:0] PH_SKIP  = 3'd0;
    localparam logic [2:0] PH_ID    = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_VALUE = 3'd3;
    localparam logic [2:0] PH_STOP  = 3'd4;

    localparam logic [2:0] KIND_HEADER   = 3'd0;
    localparam logic [2:0] KIND_SSID     = 3'd1;
    localparam logic [2:0] KIND_RATE     = 3'd2;
    localparam logic [2:0] KIND_EXT_RATE = 3'd3;
    localparam logic [2:0] KIND_OUI      = 3'd4;
    localparam logic [2:0] KIND_VTYPE    = 3'd5;
    localparam logic [2:0] KIND_VPAYLOAD = 3'd6;
    localparam logic [2:0] KIND_SUMMARY  = 3'd7;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] ie_id;
        logic [7:0] value;
        logic [7:0] position;
        logic [5:0] element_count;
        logic [4:0] rate_count;
        logic [4:0] ext_rate_count;
        logic       ht_present;
        logic       vht_present;
        logic [3:0] vendor_count;
        logic       last_result;
    } t_result;

    typedef struct packed {
        logic [1:0] n;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

// ----- rtl/core/wlan_info_element_parser.sv -----
// ----------------------------------------------------------------------------
// wlan_info_element_parser
// Information element parser for management frame bodies, one byte per item.
// ----------------------------------------------------------------------------
// Takes one body byte per cycle unless held off. Each byte passes an input
// register, is parsed combinationally against the per-frame state, and its
// results (at most two: a data or header result, plus the summary on the
// final byte) go into a four-entry result queue that drains one result per
// cycle while the output is ready. A byte's results are written into the queue
// as it leaves the input register. Input is held off while the queue has
// fewer than two free entries. The first byte of every frame gives at most one
// result, so with the output always ready the queue never holds more than two
// results and input never stalls; stalls come only from output back-pressure.
// ----------------------------------------------------------------------------
module wlan_info_element_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // data_byte[7:0], frame_length[19:8], zero pad
    input  logic        s_axis_tuser,   // frame_start
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,     // fixed_skip
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // ie_id, value, position, element_count,
                                        // rate_count, ext_rate_count, ht_present,
                                        // vht_present, vendor_count, zero pad
    output logic [2:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast    // last_result
);

    wiep_pkg::t_push   w_push;
    wiep_pkg::t_result w_res;
    logic              w_space_ok;

    assign o_cfg_ready = 1'b1;

    wiep_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_data_byte    (s_axis_tdata[7:0]),
        .i_frame_length (s_axis_tdata[19:8]),
        .i_frame_start  (s_axis_tuser),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_space_ok     (w_space_ok),
        .o_push         (w_push)
    );

    wiep_result_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .o_space_ok (w_space_ok),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (w_res)
    );

    assign m_axis_tdata = {2'b00,
                           w_res.vendor_count,
                           w_res.vht_present,
                           w_res.ht_present,
                           w_res.ext_rate_count,
                           w_res.rate_count,
                           w_res.element_count,
                           w_res.position,
                           w_res.value,
                           w_res.ie_id};
    assign m_axis_tuser = w_res.kind;
    assign m_axis_tlast = w_res.last_result;

endmodule

// ----- rtl/core/wiep_parser.sv -----
// ----------------------------------------------------------------------------
// wiep_parser
// Input register, per-frame parse state and result generation per body byte.
// ----------------------------------------------------------------------------
module wiep_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [7:0]      i_data_byte,
    input  logic [11:0]     i_frame_length,
    input  logic            i_frame_start,
    input  logic            i_cfg_valid,
    input  logic [7:0]      i_cfg_data,
    input  logic            i_space_ok,
    output wiep_pkg::t_push o_push
);

    logic        r_in_vld;
    logic [7:0]  r_in_data;
    logic [11:0] r_in_len;
    logic        r_in_start;
    logic [7:0]  r_skip;

    logic [2:0]  r_phase, n_phase;
    logic [11:0] r_off, n_off;
    logic [11:0] r_total, n_total;
    logic [7:0]  r_cur_id, n_cur_id;
    logic [7:0]  r_cur_len, n_cur_len;
    logic [7:0]  r_vidx, n_vidx;
    logic [5:0]  r_elems, n_elems;
    logic [4:0]  r_rates, n_rates;
    logic [4:0]  r_xrates, n_xrates;
    logic        r_ht, n_ht;
    logic        r_vht, n_vht;
    logic [3:0]  r_vendors, n_vendors;
    logic        r_vactive, n_vactive;

    logic        w_consume;
    logic        w_data;
    logic        w_sum;
    logic [2:0]  w_kind;
    logic [7:0]  w_value;
    logic [7:0]  w_pos;
    wiep_pkg::t_result w_dres;
    wiep_pkg::t_result w_sres;

    assign w_consume  = r_in_vld && i_space_ok;
    assign o_in_ready = !r_in_vld || w_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data  <= i_data_byte;
            r_in_len   <= i_frame_length;
            r_in_start <= i_frame_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= wiep_pkg::SKIP_RESET;
        end else if (i_cfg_valid) begin
            r_skip <= i_cfg_data;
        end
    end

    always_comb begin : parse
        logic        go;
        logic [11:0] p;
        logic [12:0] p_end;
        logic [7:0]  b;
        logic [7:0]  i;
        b       = r_in_data;
        p       = '0;
        p_end   = '0;
        i       = '0;
        go      = 1'b0;
        n_phase   = r_phase;
        n_off     = r_off;
        n_total   = r_total;
        n_cur_id  = r_cur_id;
        n_cur_len = r_cur_len;
        n_vidx    = r_vidx;
        n_elems   = r_elems;
        n_rates   = r_rates;
        n_xrates  = r_xrates;
        n_ht      = r_ht;
        n_vht     = r_vht;
        n_vendors = r_vendors;
        n_vactive = r_vactive;
        w_data  = 1'b0;
        w_sum   = 1'b0;
        w_kind  = wiep_pkg::KIND_HEADER;
        w_value = '0;
        w_pos   = '0;
        if (w_consume) begin
            if (r_in_start) begin
                n_phase   = wiep_pkg::PH_SKIP;
                n_off     = '0;
                n_total   = r_in_len;
                n_cur_id  = '0;
                n_cur_len = '0;
                n_vidx    = '0;
                n_elems   = '0;
                n_rates   = '0;
                n_xrates  = '0;
                n_ht      = 1'b0;
                n_vht     = 1'b0;
                n_vendors = '0;
                n_vactive = 1'b0;
                go        = 1'b1;
            end else begin
                go = (r_off < r_total);
            end
            if (go) begin
                p     = n_off;
                p_end = {1'b0, p} + 13'd1;
                if (p < n_total) begin
                    if (n_phase == wiep_pkg::PH_SKIP && p >= {4'd0, r_skip}) begin
                        n_phase = wiep_pkg::PH_ID;
                    end
                    case (n_phase)
                        wiep_pkg::PH_ID: begin
                            if (p_end < {1'b0, n_total} && n_elems < wiep_pkg::ELEMENT_CAP) begin
                                n_cur_id = b;
                                n_phase  = wiep_pkg::PH_LEN;
                            end else begin
                                n_phase = wiep_pkg::PH_STOP;
                            end
                        end
                        wiep_pkg::PH_LEN: begin
                            n_cur_len = b;
                            if (p_end + {5'd0, b} <= {1'b0, n_total}) begin
                                n_elems   = n_elems + 6'd1;
                                n_vidx    = '0;
                                n_vactive = 1'b0;
                                if (n_cur_id == wiep_pkg::ID_HT && b >= wiep_pkg::HT_MIN_LEN) begin
                                    n_ht = 1'b1;
                                end
                                if (n_cur_id == wiep_pkg::ID_VHT
                                        && b >= wiep_pkg::VHT_MIN_LEN) begin
                                    n_vht = 1'b1;
                                end
                                if (n_cur_id == wiep_pkg::ID_VENDOR
                                        && b >= wiep_pkg::VENDOR_MIN_LEN
                                        && n_vendors < wiep_pkg::VENDOR_CAP) begin
                                    n_vendors = n_vendors + 4'd1;
                                    n_vactive = 1'b1;
                                end
                                w_data  = 1'b1;
                                w_kind  = wiep_pkg::KIND_HEADER;
                                w_value = b;
                                w_pos   = '0;
                                n_phase = (b == 8'd0) ? wiep_pkg::PH_ID : wiep_pkg::PH_VALUE;
                            end else begin
                                n_phase = wiep_pkg::PH_STOP;
                            end
                        end
                        wiep_pkg::PH_VALUE: begin
                            i     = n_vidx;
                            w_pos = i;
                            if (n_cur_id == wiep_pkg::ID_SSID) begin
                                if (n_cur_len >= 8'd1 && n_cur_len <= wiep_pkg::SSID_MAX_LEN
                                        && b >= wiep_pkg::PRINT_LO
                                        && b <= wiep_pkg::PRINT_HI) begin
                                    w_data  = 1'b1;
                                    w_kind  = wiep_pkg::KIND_SSID;
                                    w_value = b;
                                end
                            end else if (n_cur_id == wiep_pkg::ID_RATES) begin
                                if (n_cur_len <= wiep_pkg::RATE_MAX_LEN
                                        && n_rates < wiep_pkg::RATE_CAP) begin
                                    n_rates = n_rates + 5'd1;
                                    w_data  = 1'b1;
                                    w_kind  = wiep_pkg::KIND_RATE;
                                    w_value = b & wiep_pkg::RATE_MASK;
                                end
                            end else if (n_cur_id == wiep_pkg::ID_EXT_RATES) begin
                                if (n_cur_len <= wiep_pkg::RATE_MAX_LEN
                                        && n_xrates < wiep_pkg::RATE_CAP) begin
                                    n_xrates = n_xrates + 5'd1;
                                    w_data   = 1'b1;
                                    w_kind   = wiep_pkg::KIND_EXT_RATE;
                                    w_value  = b & wiep_pkg::RATE_MASK;
                                end
                            end else if (n_cur_id == wiep_pkg::ID_VENDOR && n_vactive) begin
                                w_value = b;
                                if (i < wiep_pkg::VENDOR_TYPE_POS) begin
                                    w_data = 1'b1;
                                    w_kind = wiep_pkg::KIND_OUI;
                                end else if (i == wiep_pkg::VENDOR_TYPE_POS) begin
                                    w_data = 1'b1;
                                    w_kind = wiep_pkg::KIND_VTYPE;
                                end else if (i - wiep_pkg::VENDOR_PAY_POS
                                        < wiep_pkg::VENDOR_PAYLOAD_CAP) begin
                                    w_data = 1'b1;
                                    w_kind = wiep_pkg::KIND_VPAYLOAD;
                                end
                            end
                            n_vidx = i + 8'd1;
                            if (n_vidx >= n_cur_len) begin
                                n_phase = wiep_pkg::PH_ID;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                n_off = p_end[11:0];
                if (p_end >= {1'b0, n_total}) begin
                    w_sum   = 1'b1;
                    n_off   = n_total;
                    n_phase = wiep_pkg::PH_STOP;
                end
            end
        end
    end

    always_comb begin
        w_dres.kind           = w_kind;
        w_dres.ie_id          = n_cur_id;
        w_dres.value          = w_value;
        w_dres.position       = w_pos;
        w_dres.element_count  = n_elems;
        w_dres.rate_count     = n_rates;
        w_dres.ext_rate_count = n_xrates;
        w_dres.ht_present     = n_ht;
        w_dres.vht_present    = n_vht;
        w_dres.vendor_count   = n_vendors;
        w_dres.last_result    = 1'b0;
        w_sres                = w_dres;
        w_sres.kind           = wiep_pkg::KIND_SUMMARY;
        w_sres.ie_id          = '0;
        w_sres.value          = '0;
        w_sres.position       = '0;
        w_sres.last_result    = 1'b1;
        o_push.n    = {1'b0, w_data} + {1'b0, w_sum};
        o_push.res0 = w_data ? w_dres : w_sres;
        o_push.res1 = w_sres;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= wiep_pkg::PH_SKIP;
            r_off     <= '0;
            r_total   <= '0;
            r_cur_id  <= '0;
            r_cur_len <= '0;
            r_vidx    <= '0;
            r_elems   <= '0;
            r_rates   <= '0;
            r_xrates  <= '0;
            r_ht      <= 1'b0;
            r_vht     <= 1'b0;
            r_vendors <= '0;
            r_vactive <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_off     <= n_off;
            r_total   <= n_total;
            r_cur_id  <= n_cur_id;
            r_cur_len <= n_cur_len;
            r_vidx    <= n_vidx;
            r_elems   <= n_elems;
            r_rates   <= n_rates;
            r_xrates  <= n_xrates;
            r_ht      <= n_ht;
            r_vht     <= n_vht;
            r_vendors <= n_vendors;
            r_vactive <= n_vactive;
        end
    end

    a_off_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_off <= r_total) else $error("body offset past body length");

    a_two_means_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.n == 2'd2) |-> (o_push.res1.last_result && !o_push.res0.last_result))
        else $error("second result of an item is not the summary");

    a_stop_after_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.n != 2'd0 && o_push.res1.last_result && w_sum)
        |=> (r_phase == wiep_pkg::PH_STOP && r_off == r_total))
        else $error("parser not stopped after summary");

    a_elem_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_elems <= wiep_pkg::ELEMENT_CAP) else $error("element count over cap");

endmodule

// ----- rtl/core/wiep_result_fifo.sv -----
// ----------------------------------------------------------------------------
// wiep_result_fifo
// Small result queue: up to two writes per cycle, one read per cycle when ready.
// ----------------------------------------------------------------------------
module wiep_result_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wiep_pkg::t_push   i_push,
    output logic              o_space_ok,
    output logic              o_valid,
    input  logic              i_ready,
    output wiep_pkg::t_result o_result
);

    wiep_pkg::t_result r_mem [wiep_pkg::Q_DEPTH];

    logic [wiep_pkg::Q_AW-1:0] r_wr;
    logic [wiep_pkg::Q_AW-1:0] r_rd;
    logic [wiep_pkg::Q_CW-1:0] r_cnt;
    logic                      w_pop;

    assign o_space_ok = (r_cnt <= wiep_pkg::Q_CW'(wiep_pkg::Q_DEPTH - 2));
    assign o_valid    = (r_cnt != '0);
    assign o_result   = r_mem[r_rd];
    assign w_pop      = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[r_wr + wiep_pkg::Q_AW'(1)] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + wiep_pkg::Q_AW'(i_push.n);
            r_rd  <= r_rd + wiep_pkg::Q_AW'(w_pop);
            r_cnt <= r_cnt + wiep_pkg::Q_CW'(i_push.n) - wiep_pkg::Q_CW'(w_pop);
        end
    end

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the information element parser: a directed table
// of body bytes, then random frames built from well-formed element runs
// (with truncation, aborts, caps and stray bytes) under several skip values.
// Results are checked against a built-in parser model or the table's expected rows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int ITEMS       = 1300;
    localparam int CALM_ITEMS  = 200;
    localparam int HOLD_CYCLES = 80;
    localparam int LIMIT       = 300000;

    typedef struct {
        logic [7:0]        b;
        logic [11:0]       flen;
        logic              st;
        bit                cfg_en;
        logic [7:0]        cfg_v;
        int                typed;     // -1 model, 0 no result, 1 one result in want
        wiep_pkg::t_result want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // data_byte[7:0], frame_length[19:8], zero pad
    logic        s_axis_tuser;   // frame_start
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;     // fixed_skip
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // ie_id, value, position, element_count,
                                 // rate_count, ext_rate_count, ht_present,
                                 // vht_present, vendor_count, zero pad
    logic [2:0]  m_axis_tuser;   // kind
    logic        m_axis_tlast;   // last_result

    wlan_info_element_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // parser model state
    logic [7:0]  skip_reg;
    logic [2:0]  fsm_phase;
    logic [11:0] body_pos;
    logic [11:0] body_len;
    logic [7:0]  elem_id;
    logic [7:0]  elem_len;
    logic [7:0]  val_idx;
    logic [5:0]  cnt_elem;
    logic [4:0]  cnt_rate;
    logic [4:0]  cnt_xrate;
    logic        ht_seen;
    logic        vht_seen;
    logic [3:0]  cnt_vendor;
    logic        vendor_live;

    wiep_pkg::t_result pending[$];
    int      n_errors = 0;
    int      n_results = 0;
    int      n_bytes = 0;
    int      cycles = 0;
    int      base = 0;
    bit      calm = 1'b0;
    bit      hold_out = 1'b0;
    bit      recv_gaps = 1'b1;
    bit      sender_gaps = 1'b1;

    function automatic wiep_pkg::t_result mk_res(logic [2:0] k, logic [7:0] id, logic [7:0] v,
                                                 logic [7:0] pos, logic last);
        wiep_pkg::t_result r;
        r.kind           = k;
        r.ie_id          = id;
        r.value          = v;
        r.position       = pos;
        r.element_count  = cnt_elem;
        r.rate_count     = cnt_rate;
        r.ext_rate_count = cnt_xrate;
        r.ht_present     = ht_seen;
        r.vht_present    = vht_seen;
        r.vendor_count   = cnt_vendor;
        r.last_result    = last;
        return r;
    endfunction

    task automatic restart_frame(input logic [11:0] flen);
        fsm_phase   = wiep_pkg::PH_SKIP;
        body_pos    = '0;
        body_len    = flen;
        elem_id     = '0;
        elem_len    = '0;
        val_idx     = '0;
        cnt_elem    = '0;
        cnt_rate    = '0;
        cnt_xrate   = '0;
        ht_seen     = 1'b0;
        vht_seen    = 1'b0;
        cnt_vendor  = '0;
        vendor_live = 1'b0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic [11:0] flen, input logic st);
        int         p;
        int         tot;
        logic [7:0] i;
        if (st) begin
            restart_frame(flen);
        end else if (body_pos >= body_len) begin
            return;
        end
        p   = body_pos;
        tot = body_len;
        if (p < tot) begin
            if (fsm_phase == wiep_pkg::PH_SKIP && p >= int'(skip_reg))
                fsm_phase = wiep_pkg::PH_ID;
            if (fsm_phase == wiep_pkg::PH_ID) begin
                if (p + 1 < tot && cnt_elem < wiep_pkg::ELEMENT_CAP) begin
                    elem_id   = b;
                    fsm_phase = wiep_pkg::PH_LEN;
                end else begin
                    fsm_phase = wiep_pkg::PH_STOP;
                end
            end else if (fsm_phase == wiep_pkg::PH_LEN) begin
                elem_len = b;
                if (p + int'(elem_len) + 1 <= tot) begin
                    cnt_elem++;
                    val_idx     = '0;
                    vendor_live = 1'b0;
                    if (elem_id == wiep_pkg::ID_HT && elem_len >= wiep_pkg::HT_MIN_LEN)
                        ht_seen = 1'b1;
                    if (elem_id == wiep_pkg::ID_VHT && elem_len >= wiep_pkg::VHT_MIN_LEN)
                        vht_seen = 1'b1;
                    if (elem_id == wiep_pkg::ID_VENDOR && elem_len >= wiep_pkg::VENDOR_MIN_LEN &&
                        cnt_vendor < wiep_pkg::VENDOR_CAP) begin
                        cnt_vendor++;
                        vendor_live = 1'b1;
                    end
                    pending.push_back(mk_res(wiep_pkg::KIND_HEADER, elem_id, elem_len, 8'd0,
                                             1'b0));
                    fsm_phase = (elem_len == 8'd0) ? wiep_pkg::PH_ID : wiep_pkg::PH_VALUE;
                end else begin
                    fsm_phase = wiep_pkg::PH_STOP;
                end
            end else if (fsm_phase == wiep_pkg::PH_VALUE) begin
                i = val_idx;
                if (elem_id == wiep_pkg::ID_SSID) begin
                    if (elem_len >= 8'd1 && elem_len <= wiep_pkg::SSID_MAX_LEN &&
                        b >= wiep_pkg::PRINT_LO && b <= wiep_pkg::PRINT_HI)
                        pending.push_back(mk_res(wiep_pkg::KIND_SSID, elem_id, b, i, 1'b0));
                end else if (elem_id == wiep_pkg::ID_RATES) begin
                    if (elem_len <= wiep_pkg::RATE_MAX_LEN && cnt_rate < wiep_pkg::RATE_CAP) begin
                        cnt_rate++;
                        pending.push_back(mk_res(wiep_pkg::KIND_RATE, elem_id,
                                                 b & wiep_pkg::RATE_MASK, i, 1'b0));
                    end
                end else if (elem_id == wiep_pkg::ID_EXT_RATES) begin
                    if (elem_len <= wiep_pkg::RATE_MAX_LEN && cnt_xrate < wiep_pkg::RATE_CAP) begin
                        cnt_xrate++;
                        pending.push_back(mk_res(wiep_pkg::KIND_EXT_RATE, elem_id,
                                                 b & wiep_pkg::RATE_MASK, i, 1'b0));
                    end
                end else if (elem_id == wiep_pkg::ID_VENDOR && vendor_live) begin
                    if (i < wiep_pkg::VENDOR_TYPE_POS)
                        pending.push_back(mk_res(wiep_pkg::KIND_OUI, elem_id, b, i, 1'b0));
                    else if (i == wiep_pkg::VENDOR_TYPE_POS)
                        pending.push_back(mk_res(wiep_pkg::KIND_VTYPE, elem_id, b, i, 1'b0));
                    else if (i - wiep_pkg::VENDOR_PAY_POS < wiep_pkg::VENDOR_PAYLOAD_CAP)
                        pending.push_back(mk_res(wiep_pkg::KIND_VPAYLOAD, elem_id, b, i,
                                                 1'b0));
                end
                val_idx = i + 8'd1;
                if (val_idx >= elem_len) fsm_phase = wiep_pkg::PH_ID;
            end
        end
        body_pos = 12'(p + 1);
        if (p + 1 >= tot) begin
            pending.push_back(mk_res(wiep_pkg::KIND_SUMMARY, 8'd0, 8'd0, 8'd0, 1'b1));
            body_pos  = body_len;
            fsm_phase = wiep_pkg::PH_STOP;
        end
    endtask

    task automatic note_mismatch(input string what);
        n_errors++;
        $display("mismatch @%0t result %0d: %s", $realtime, n_results, what);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) note_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // result checker
    wiep_pkg::t_result got_res;
    wiep_pkg::t_result want_res;
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_res.kind           = m_axis_tuser;
            got_res.ie_id          = m_axis_tdata[7:0];
            got_res.value          = m_axis_tdata[15:8];
            got_res.position       = m_axis_tdata[23:16];
            got_res.element_count  = m_axis_tdata[29:24];
            got_res.rate_count     = m_axis_tdata[34:30];
            got_res.ext_rate_count = m_axis_tdata[39:35];
            got_res.ht_present     = m_axis_tdata[40];
            got_res.vht_present    = m_axis_tdata[41];
            got_res.vendor_count   = m_axis_tdata[45:42];
            got_res.last_result    = m_axis_tlast;
            if (pending.size() == 0) begin
                note_mismatch($sformatf("unexpected result kind %0d", got_res.kind));
            end else begin
                want_res = pending.pop_front();
                check_field("kind", got_res.kind, want_res.kind);
                check_field("ie_id", got_res.ie_id, want_res.ie_id);
                check_field("value", got_res.value, want_res.value);
                check_field("position", got_res.position, want_res.position);
                check_field("element_count", got_res.element_count, want_res.element_count);
                check_field("rate_count", got_res.rate_count, want_res.rate_count);
                check_field("ext_rate_count", got_res.ext_rate_count,
                            want_res.ext_rate_count);
                check_field("ht_present", got_res.ht_present, want_res.ht_present);
                check_field("vht_present", got_res.vht_present, want_res.vht_present);
                check_field("vendor_count", got_res.vendor_count, want_res.vendor_count);
                check_field("last_result", got_res.last_result, want_res.last_result);
            end
            n_results++;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result sink: random stalls, one long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_out) begin
                hold_out = 1'b0;
                m_axis_tready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++) @(posedge i_clk);
            end else if (recv_gaps && !calm && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            if ($urandom_range(0, 63) == 0) recv_gaps = !recv_gaps;
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic [11:0] flen, input logic st);
        if (sender_gaps && !calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, flen, b};
        s_axis_tuser  <= st;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        base = pending.size();
        parse_byte(b, flen, st);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_skip(input logic [7:0] v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        skip_reg = v;
        @(posedge i_clk);
    endtask

    task automatic run_frame();
        logic [7:0] body[$];
        logic [7:0] el_id;
        int         mode;
        int         n_el;
        int         el_len;
        int         sel;
        int         flen;
        int         n_send;
        mode = $urandom_range(0, 9);
        sender_gaps = !calm && ($urandom_range(0, 3) != 0);
        if (skip_reg > 8'd40 && $urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(1, 30)) body.push_back(8'($urandom));
        end else begin
            repeat (skip_reg) body.push_back(8'($urandom));
            n_el = (mode == 0) ? $urandom_range(30, 40) :
                   (mode <= 2) ? $urandom_range(3, 8) : $urandom_range(1, 6);
            repeat (n_el) begin
                if (mode == 0 && $urandom_range(0, 1) == 1) sel = 5;
                else if (mode == 1 && $urandom_range(0, 1) == 1) sel = $urandom_range(1, 2);
                else sel = $urandom_range(0, 7);
                case (sel)
                    0: begin
                        el_id  = wiep_pkg::ID_SSID;
                        el_len = ($urandom_range(0, 5) == 0) ? $urandom_range(33, 40) :
                                                              $urandom_range(0, 32);
                    end
                    1: begin
                        el_id  = wiep_pkg::ID_RATES;
                        el_len = $urandom_range(0, 18);
                    end
                    2: begin
                        el_id  = wiep_pkg::ID_EXT_RATES;
                        el_len = $urandom_range(0, 18);
                    end
                    3: begin
                        el_id  = wiep_pkg::ID_HT;
                        el_len = $urandom_range(20, 30);
                    end
                    4: begin
                        el_id  = wiep_pkg::ID_VHT;
                        el_len = $urandom_range(8, 14);
                    end
                    5: begin
                        el_id  = wiep_pkg::ID_VENDOR;
                        el_len = (mode == 2) ? $urandom_range(60, 100) : $urandom_range(0, 12);
                    end
                    default: begin
                        el_id  = 8'($urandom);
                        el_len = $urandom_range(0, 10);
                    end
                endcase
                if (mode == 0)
                    el_len = (el_id == wiep_pkg::ID_VENDOR) ? $urandom_range(3, 5) :
                                                              $urandom_range(0, 2);
                body.push_back(el_id);
                body.push_back(8'(el_len));
                repeat (el_len)
                    body.push_back((el_id == wiep_pkg::ID_SSID && $urandom_range(0, 3) != 0) ?
                                   8'($urandom_range(32, 126)) : 8'($urandom));
            end
            if ($urandom_range(0, 7) == 0) body.push_back(8'($urandom));
        end
        flen   = body.size();
        n_send = flen;
        case ($urandom_range(0, 19))
            0, 1, 2: begin
                flen   = $urandom_range(1, body.size());
                n_send = flen;
            end
            3: begin
                flen   = 0;
                n_send = 1;
            end
            4: n_send = $urandom_range(1, body.size());
            default: ;
        endcase
        for (int k = 0; k < n_send; k++) begin
            push_byte(body[k], (k == 0) ? 12'(flen) : 12'($urandom), k == 0);
            n_bytes++;
            if (n_bytes == 400) hold_out = 1'b1;
            if (n_bytes >= ITEMS - CALM_ITEMS) calm = 1'b1;
        end
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 12'($urandom), 1'b0);
    endtask

    function automatic t_row mk_row(logic [7:0] b, logic [11:0] flen, logic st,
                                    bit cfg_en, logic [7:0] cfg_v, int typed);
        t_row r;
        r.b      = b;
        r.flen   = flen;
        r.st     = st;
        r.cfg_en = cfg_en;
        r.cfg_v  = cfg_v;
        r.typed  = typed;
        r.want   = '0;
        r.want.kind        = wiep_pkg::KIND_SUMMARY;
        r.want.last_result = 1'b1;
        return r;
    endfunction

    t_row rows[$];
    int   phase_no;
    logic [7:0] skip_v;

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        skip_reg = wiep_pkg::SKIP_RESET;
        restart_frame(12'd0);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset, skip 12: stray byte, empty frame, skip past body, stray byte
        rows.push_back(mk_row(8'hA5, 12'd0,   1'b0, 0, 8'd0, 0));
        rows.push_back(mk_row(8'h00, 12'd0,   1'b1, 0, 8'd0, 1));
        rows.push_back(mk_row(8'hFF, 12'd1,   1'b1, 0, 8'd0, 1));
        rows.push_back(mk_row(8'h7E, 12'hFFF, 1'b0, 0, 8'd0, 0));
        // skip 0: ssid with printable and control byte, then rates
        rows.push_back(mk_row(wiep_pkg::ID_SSID, 12'd8, 1'b1, 1, 8'd0, -1));
        rows.push_back(mk_row(8'h02, 12'd0, 1'b0, 0, 8'd0, -1));
        rows.push_back(mk_row(8'h41, 12'd0, 1'b0, 0, 8'd0, -1));
        rows.push_back(mk_row(8'h1F, 12'd0, 1'b0, 0, 8'd0, -1));
        rows.push_back(mk_row(wiep_pkg::ID_RATES, 12'd0, 1'b0, 0, 8'd0, -1));
        rows.push_back(mk_row(8'h02, 12'd0, 1'b0, 0, 8'd0, -1));
        rows.push_back(mk_row(8'hFF, 12'd0, 1'b0, 0, 8'd0, -1));
        rows.push_back(mk_row(8'h80, 12'd0, 1'b0, 0, 8'd0, -1));
        // vendor of length 3, then a lone id byte at the body end
        rows.push_back(mk_row(wiep_pkg::ID_VENDOR, 12'd6, 1'b1, 0, 8'd0, -1));
        rows.push_back(mk_row(8'h03, 12'd0, 1'b0, 0, 8'd0, -1));
        rows.push_back(mk_row(8'h00, 12'd0, 1'b0, 0, 8'd0, -1));
        rows.push_back(mk_row(8'h50, 12'd0, 1'b0, 0, 8'd0, -1));
        rows.push_back(mk_row(8'hF2, 12'd0, 1'b0, 0, 8'd0, -1));
        rows.push_back(mk_row(wiep_pkg::ID_HT, 12'd0, 1'b0, 0, 8'd0, -1));
        // HT element running past the body end
        rows.push_back(mk_row(wiep_pkg::ID_HT, 12'd10, 1'b1, 0, 8'd0, -1));
        rows.push_back(mk_row(8'h1A, 12'd0,  1'b0, 0, 8'd0, -1));
        // restart mid frame: zero-length ssid filling the last two bytes
        rows.push_back(mk_row(wiep_pkg::ID_SSID, 12'd2, 1'b1, 0, 8'd0, -1));
        rows.push_back(mk_row(8'h00, 12'd0, 1'b0, 0, 8'd0, -1));
        // longest body, left open
        rows.push_back(mk_row(8'hFF, 12'hFFF, 1'b1, 0, 8'd0, -1));

        foreach (rows[r]) begin
            if (rows[r].cfg_en) write_skip(rows[r].cfg_v);
            push_byte(rows[r].b, rows[r].flen, rows[r].st);
            if (rows[r].typed >= 0) begin
                while (pending.size() > base) void'(pending.pop_back());
                if (rows[r].typed == 1) pending.push_back(rows[r].want);
            end
        end

        phase_no = 0;
        while (n_bytes < ITEMS) begin
            case (phase_no)
                0: skip_v = 8'd0;
                1: skip_v = 8'd255;
                2: skip_v = wiep_pkg::SKIP_RESET;
                default: skip_v = ($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(0, 24));
            endcase
            write_skip(skip_v);
            repeat ((skip_v > 8'd40) ? 2 : $urandom_range(4, 8))
                if (n_bytes < ITEMS) run_frame();
            phase_no++;
        end

        s_axis_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- wlan_info_element_parser.f -----
rtl/core/wiep_pkg.sv
rtl/core/wiep_parser.sv
rtl/core/wiep_result_fifo.sv
rtl/core/wlan_info_element_parser.sv
dv/tb.sv
